/* rtl/ppw_pkg.sv */
// ----------------------------------------------------------------------------
// ppw_pkg
// Widths, register indexes and types shared by the point projection block.
// ----------------------------------------------------------------------------
package ppw_pkg;

	localparam int PT_W     = 21;
	localparam int D_W      = 22;
	localparam int WT_W     = 16;
	localparam int PROD_W   = 38;
	localparam int ACC_W    = 40;
	localparam int MAG_W    = 39;
	localparam int FAC_W    = 32;
	localparam int HALF_W   = 16;
	localparam int M1_W     = 41;
	localparam int WM_W     = 50;
	localparam int WZ_W     = 58;
	localparam int TT_W     = 60;
	localparam int TTM_W    = 57;
	localparam int OUT_W    = 32;
	localparam int DIV_STEPS = 32;
	localparam int ROW_W    = 48;
	localparam int CTR_W    = 63;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZOS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERSP  = 3'd6;

	localparam logic [ROW_W-1:0] ROW_X_RST  = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0] ROW_Y_RST  = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RST  = 48'h4000_0000_0000;
	localparam logic [FAC_W-1:0] ZOS_RST    = 32'd167772;
	localparam logic [FAC_W-1:0] ASPECT_RST = 32'd16777216;

	localparam logic signed [TT_W-1:0] TT_ONE = 60'sd16777216;
	localparam logic signed [TT_W-1:0] TT_MIN = 60'sd16777;

	typedef struct packed {
		logic            neg_x;
		logic            neg_y;
		logic            div;
		logic            ovf_x;
		logic            ovf_y;
		logic [WM_W-1:0] wxm;
		logic [WM_W-1:0] wym;
	} side_t;

endpackage

/* rtl/ppw_if.sv */
// ----------------------------------------------------------------------------
// ppw channel interfaces
// Point input, window output and configuration write channels.
// ----------------------------------------------------------------------------
interface ppw_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ppw_pkg::PT_W-1:0]      point_x;
	logic signed [ppw_pkg::PT_W-1:0]      point_y;
	logic signed [ppw_pkg::PT_W-1:0]      point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppw_window_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ppw_pkg::OUT_W-1:0]     window_x;
	logic signed [ppw_pkg::OUT_W-1:0]     window_y;
	logic                                 divided;
	modport source (output valid, window_x, window_y, divided, input ready);
	modport sink (input valid, window_x, window_y, divided, output ready);
endinterface

interface ppw_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ppw_pkg::CFG_IDX_W-1:0]        index;
	logic [ppw_pkg::CFG_DATA_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ppw_div.sv */
// ----------------------------------------------------------------------------
// ppw_div
// Pipelined restoring divider, one quotient bit per stage, for x and y.
// ----------------------------------------------------------------------------
module ppw_div (
	input  logic                                   clk,
	input  logic [ppw_pkg::DIV_STEPS-1:0]          en,
	input  logic [ppw_pkg::TTM_W-1:0]              tt_in,
	input  logic [ppw_pkg::TTM_W-1:0]              rx_in,
	input  logic [ppw_pkg::TTM_W-1:0]              ry_in,
	input  logic [ppw_pkg::DIV_STEPS-1:0]          nx_in,
	input  logic [ppw_pkg::DIV_STEPS-1:0]          ny_in,
	input  ppw_pkg::side_t                         side_in,
	output logic [ppw_pkg::DIV_STEPS-1:0]          qx,
	output logic [ppw_pkg::DIV_STEPS-1:0]          qy,
	output ppw_pkg::side_t                         side_out
);
	import ppw_pkg::*;

	logic [TTM_W-1:0]     tt_s [DIV_STEPS+1];
	logic [TTM_W-1:0]     rx_s [DIV_STEPS+1];
	logic [TTM_W-1:0]     ry_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] nx_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] ny_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] qx_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] qy_s [DIV_STEPS+1];
	side_t                sd_s [DIV_STEPS+1];

	assign tt_s[0] = tt_in;
	assign rx_s[0] = rx_in;
	assign ry_s[0] = ry_in;
	assign nx_s[0] = nx_in;
	assign ny_s[0] = ny_in;
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign sd_s[0] = side_in;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [TTM_W:0] tx, ty;
		logic           gx, gy;
		always_comb begin
			tx = {rx_s[j], nx_s[j][DIV_STEPS-1]};
			ty = {ry_s[j], ny_s[j][DIV_STEPS-1]};
			gx = tx >= {1'b0, tt_s[j]};
			gy = ty >= {1'b0, tt_s[j]};
		end
		always_ff @(posedge clk) begin
			if (en[j]) begin
				tt_s[j+1] <= tt_s[j];
				rx_s[j+1] <= gx ? TTM_W'(tx - {1'b0, tt_s[j]}) : tx[TTM_W-1:0];
				ry_s[j+1] <= gy ? TTM_W'(ty - {1'b0, tt_s[j]}) : ty[TTM_W-1:0];
				nx_s[j+1] <= {nx_s[j][DIV_STEPS-2:0], 1'b0};
				ny_s[j+1] <= {ny_s[j][DIV_STEPS-2:0], 1'b0};
				qx_s[j+1] <= {qx_s[j][DIV_STEPS-2:0], gx};
				qy_s[j+1] <= {qy_s[j][DIV_STEPS-2:0], gy};
				sd_s[j+1] <= sd_s[j];
			end
		end
	end

	assign qx       = qx_s[DIV_STEPS];
	assign qy       = qy_s[DIV_STEPS];
	assign side_out = sd_s[DIV_STEPS];

endmodule

/* rtl/point_projection_to_window.sv */
// ----------------------------------------------------------------------------
// point_projection_to_window
// Vertex transform with perspective divide, fixed point, one point per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   point  : sink of Q13.8 world points, one transaction per point.
//   window : source of saturated Q16.16 window x/y and the divided flag,
//            one transaction per point, in input order.
//   cfg    : register writes (index, data); always ready. Write only while
//            the pipeline is empty.
// Depth: 43 register stages (10 transform stages, 32 divider stages of one
//   quotient bit each, one output register).
// Throughput: one point per cycle while the window output is not stalled;
//   the 32-stage divider sets the depth.
// Stall: each stage holds while the next is full and stalled, so bubbles are
//   squeezed out; while the output waits, points are taken until all are full.
// Reset: clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module point_projection_to_window (
	input  logic          clk,
	input  logic          arst_n,
	ppw_cfg_if.sink       cfg,
	ppw_point_if.sink     point,
	ppw_window_if.source  window
);
	import ppw_pkg::*;

	localparam int NPRE = 10;
	localparam int NST  = NPRE + DIV_STEPS + 1;

	logic [ROW_W-1:0] row_q [3];
	logic [CTR_W-1:0] center_q;
	logic [FAC_W-1:0] zos_q, aspect_q, persp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_X_RST;
			row_q[1] <= ROW_Y_RST;
			row_q[2] <= ROW_Z_RST;
			center_q <= '0;
			zos_q    <= ZOS_RST;
			aspect_q <= ASPECT_RST;
			persp_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROW_X:  row_q[0] <= cfg.data[ROW_W-1:0];
				REG_ROW_Y:  row_q[1] <= cfg.data[ROW_W-1:0];
				REG_ROW_Z:  row_q[2] <= cfg.data[ROW_W-1:0];
				REG_CENTER: center_q <= cfg.data[CTR_W-1:0];
				REG_ZOS:    zos_q    <= cfg.data[FAC_W-1:0];
				REG_ASPECT: aspect_q <= cfg.data[FAC_W-1:0];
				REG_PERSP:  persp_q  <= cfg.data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic [NST:1] v_q, en;

	always_comb begin
		en[NST] = !v_q[NST] || window.ready;
		for (int i = NST - 1; i >= 1; i--)
			en[i] = !v_q[i] || en[i+1];
	end

	assign point.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= point.valid;
			for (int i = 2; i <= NST; i++)
				if (en[i])
					v_q[i] <= v_q[i-1];
		end
	end

	// s1: offset from center
	logic signed [D_W-1:0] d_s1 [3];
	logic signed [PT_W-1:0] pt [3];
	logic signed [PT_W-1:0] ctr [3];

	always_comb begin
		pt[0] = point.point_x;
		pt[1] = point.point_y;
		pt[2] = point.point_z;
		for (int k = 0; k < 3; k++)
			ctr[k] = $signed(center_q[PT_W*k +: PT_W]);
	end

	always_ff @(posedge clk) begin
		if (en[1])
			for (int k = 0; k < 3; k++)
				d_s1[k] <= D_W'(pt[k]) - D_W'(ctr[k]);
	end

	// s2: weight products
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [WT_W-1:0]   wt [3][3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				wt[r][k] = $signed(row_q[r][WT_W*k +: WT_W]);
	end

	always_ff @(posedge clk) begin
		if (en[2])
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					prod_s2[r][k] <= PROD_W'(wt[r][k]) * PROD_W'(d_s1[k]);
	end

	// s3: row sums
	logic signed [ACC_W-1:0] acc_s3 [3];

	always_ff @(posedge clk) begin
		if (en[3])
			for (int r = 0; r < 3; r++)
				acc_s3[r] <= ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1])
					+ ACC_W'(prod_s2[r][2]);
	end

	// s4: sign and magnitude
	logic [MAG_W-1:0] mag_s4 [3];
	logic [2:0]       neg_s4;
	logic [ACC_W-1:0] acc_abs [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			acc_abs[r] = acc_s3[r][ACC_W-1] ? ACC_W'(-acc_s3[r]) : ACC_W'(acc_s3[r]);
	end

	always_ff @(posedge clk) begin
		if (en[4])
			for (int r = 0; r < 3; r++) begin
				mag_s4[r] <= acc_abs[r][MAG_W-1:0];
				neg_s4[r] <= acc_s3[r][ACC_W-1];
			end
	end

	// s5: times zoom/scale, split in halves
	localparam int P5_W = MAG_W + HALF_W;
	logic [P5_W-1:0] phi_s5 [3];
	logic [P5_W-1:0] plo_s5 [3];
	logic [2:0]      neg_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int r = 0; r < 3; r++) begin
				phi_s5[r] <= P5_W'(mag_s4[r]) * P5_W'(zos_q[FAC_W-1:HALF_W]);
				plo_s5[r] <= P5_W'(mag_s4[r]) * P5_W'(zos_q[HALF_W-1:0]);
			end
			neg_s5 <= neg_s4;
		end
	end

	// s6: combine, Q.22 * Q8.24 >> 30
	logic [P5_W:0]   sum6 [3];
	logic [M1_W-1:0] m1_s6 [3];
	logic [2:0]      neg_s6;

	always_comb begin
		for (int r = 0; r < 3; r++)
			sum6[r] = (P5_W+1)'(phi_s5[r]) + (P5_W+1)'(plo_s5[r] >> HALF_W);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int r = 0; r < 3; r++)
				m1_s6[r] <= sum6[r][14 +: M1_W];
			neg_s6 <= neg_s5;
		end
	end

	// s7: aspect on y, perspective on z
	localparam int P7_W = M1_W + HALF_W;
	logic [P7_W-1:0] ahi_s7, alo_s7, zhi_s7, zlo_s7;
	logic [M1_W-1:0] m1x_s7;
	logic [2:0]      neg_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ahi_s7 <= P7_W'(m1_s6[1]) * P7_W'(aspect_q[FAC_W-1:HALF_W]);
			alo_s7 <= P7_W'(m1_s6[1]) * P7_W'(aspect_q[HALF_W-1:0]);
			zhi_s7 <= P7_W'(m1_s6[2]) * P7_W'(persp_q[FAC_W-1:HALF_W]);
			zlo_s7 <= P7_W'(m1_s6[2]) * P7_W'(persp_q[HALF_W-1:0]);
			m1x_s7 <= m1_s6[0];
			neg_s7 <= neg_s6;
		end
	end

	// s8
	logic [WZ_W-1:0] asum, zsum;
	logic [WM_W-1:0] wxm_s8, wym_s8;
	logic [WZ_W-1:0] wzp_s8;
	logic [2:0]      neg_s8;

	always_comb begin
		asum = WZ_W'(ahi_s7) + WZ_W'(alo_s7 >> HALF_W);
		zsum = WZ_W'(zhi_s7) + WZ_W'(zlo_s7 >> HALF_W);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			wxm_s8 <= WM_W'(m1x_s7);
			wym_s8 <= asum[WZ_W-1:8];
			wzp_s8 <= zsum;
			neg_s8 <= neg_s7;
		end
	end

	// s9: depth term and divide decision
	logic signed [TT_W-1:0] tt_c, tt_s9;
	logic [WM_W-1:0]        wxm_s9, wym_s9;
	logic [1:0]             neg_s9;
	logic                   div_s9;

	always_comb begin
		if (neg_s8[2])
			tt_c = TT_ONE + $signed(TT_W'(wzp_s8));
		else
			tt_c = TT_ONE - $signed(TT_W'(wzp_s8));
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			tt_s9  <= tt_c;
			div_s9 <= (persp_q != '0) && (tt_c > TT_MIN);
			wxm_s9 <= wxm_s8;
			wym_s9 <= wym_s8;
			neg_s9 <= neg_s8[1:0];
		end
	end

	// s10: quotient range check and divider setup
	logic [TTM_W-1:0]     tt_s10, rx_s10, ry_s10;
	logic [DIV_STEPS-1:0] nx_s10, ny_s10;
	side_t                sd_s10;
	logic [TTM_W+7:0]     tt_sh;

	assign tt_sh = {tt_s9[TTM_W-1:0], 8'b0};

	always_ff @(posedge clk) begin
		if (en[10]) begin
			tt_s10       <= tt_s9[TTM_W-1:0];
			rx_s10       <= TTM_W'(wxm_s9 >> 8);
			ry_s10       <= TTM_W'(wym_s9 >> 8);
			nx_s10       <= {wxm_s9[7:0], 24'b0};
			ny_s10       <= {wym_s9[7:0], 24'b0};
			sd_s10.neg_x <= neg_s9[0];
			sd_s10.neg_y <= neg_s9[1];
			sd_s10.div   <= div_s9;
			sd_s10.ovf_x <= (TTM_W+8)'(wxm_s9) >= tt_sh;
			sd_s10.ovf_y <= (TTM_W+8)'(wym_s9) >= tt_sh;
			sd_s10.wxm   <= wxm_s9;
			sd_s10.wym   <= wym_s9;
		end
	end

	// s11..s42: divider
	logic [DIV_STEPS-1:0] qx, qy;
	side_t                sd_d;

	ppw_div u_div (
		.clk      (clk),
		.en       (en[NPRE+DIV_STEPS:NPRE+1]),
		.tt_in    (tt_s10),
		.rx_in    (rx_s10),
		.ry_in    (ry_s10),
		.nx_in    (nx_s10),
		.ny_in    (ny_s10),
		.side_in  (sd_s10),
		.qx       (qx),
		.qy       (qy),
		.side_out (sd_d)
	);

	// s43: select and saturate
	function automatic logic [OUT_W-1:0] sat(input logic [WM_W-1:0] m, input logic neg);
		logic [WM_W-1:0] lim;
		lim = WM_W'(1) << (OUT_W - 1);
		if (neg)
			sat = (m > lim) ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-m);
		else
			sat = (m >= lim) ? {1'b0, {(OUT_W-1){1'b1}}} : m[OUT_W-1:0];
	endfunction

	logic [WM_W-1:0] mx, my;
	logic [OUT_W-1:0] wx_s43, wy_s43;
	logic             dv_s43;

	always_comb begin
		if (!sd_d.div) begin
			mx = sd_d.wxm;
			my = sd_d.wym;
		end else begin
			mx = sd_d.ovf_x ? '1 : WM_W'(qx);
			my = sd_d.ovf_y ? '1 : WM_W'(qy);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			wx_s43 <= sat(mx, sd_d.neg_x);
			wy_s43 <= sat(my, sd_d.neg_y);
			dv_s43 <= sd_d.div;
		end
	end

	assign window.valid    = v_q[NST];
	assign window.window_x = $signed(wx_s43);
	assign window.window_y = $signed(wy_s43);
	assign window.divided  = dv_s43;

endmodule
